@@ hw/rtl/axsd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register indexes and the key byte lookup of the archive
// stream decryptor. No dependencies.
package axsd_pkg;

	localparam int KEY_BYTES      = 16;
	localparam int KEY_IDX_W      = $clog2(KEY_BYTES);
	localparam int KEY_W          = KEY_BYTES * 8;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int HIST_W         = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CHAINED_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3   = 3'd4;

	localparam logic [KEY_IDX_W-1:0] FIRST_WORD_LAST_IDX = 4'd3;

	typedef struct packed {
		logic             chained_mode;
		logic [KEY_W-1:0] key;
	} cfg_t;

	// Key byte i sits at bits 8*i+7 : 8*i of the packed key.
	function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
		input logic [KEY_IDX_W-1:0] idx);
		logic [7:0] b;
		b = key[idx*8 +: 8];
		return b;
	endfunction

endpackage

@@ hw/rtl/axsd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready stream interfaces for ciphertext requests and plaintext results.
// Depends on nothing.
interface axsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_byte;
	logic       end_of_member;

	modport source (output valid, cipher_byte, end_of_member, input ready);
	modport sink (input valid, cipher_byte, end_of_member, output ready);
endinterface

interface axsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_byte;
	logic       last_out;

	modport source (output valid, plain_byte, last_out, input ready);
	modport sink (input valid, plain_byte, last_out, output ready);
endinterface

@@ hw/rtl/archive_xor_stream_decryptor.sv @@
`timescale 1ns / 1ps
// Archive member stream decryptor, one ciphertext byte in, one plaintext byte out.
// Datapath: an accepted request is captured in the input register and moves into
// the result register, from which it is offered, once that register is free.
// Throughput: one byte per cycle, set by the single XOR stage between the
// input register and the result register; stalls only when results are not taken.
// Reset: clears the mode bit, the key, the member position and the history.
module archive_xor_stream_decryptor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [axsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [axsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	axsd_in_if.sink                          in_ch,
	axsd_out_if.source                       out_ch
);

	axsd_pkg::cfg_t cfg;

	axsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	axsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

@@ hw/rtl/axsd_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration registers: mode bit and the 128-bit key.
// Depends on axsd_pkg.
module axsd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [axsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [axsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output axsd_pkg::cfg_t                   cfg
);

	logic                         chained_mode_q;
	logic [axsd_pkg::KEY_W-1:0]   key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chained_mode_q <= 1'b0;
			key_q          <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				axsd_pkg::REG_CHAINED_MODE: chained_mode_q <= cfg_wdata[0];
				axsd_pkg::REG_KEY_WORD_0:   key_q[31:0]    <= cfg_wdata;
				axsd_pkg::REG_KEY_WORD_1:   key_q[63:32]   <= cfg_wdata;
				axsd_pkg::REG_KEY_WORD_2:   key_q[95:64]   <= cfg_wdata;
				axsd_pkg::REG_KEY_WORD_3:   key_q[127:96]  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.chained_mode = chained_mode_q;
	assign cfg.key          = key_q;

endmodule

@@ hw/rtl/axsd_core.sv @@
`timescale 1ns / 1ps
// Decrypt datapath: input register, member position and ciphertext history,
// XOR logic and the result register. Depends on axsd_pkg and axsd_if.
module axsd_core (
	input  logic            clk,
	input  logic            arst_n,
	input  axsd_pkg::cfg_t  cfg,
	axsd_in_if.sink         in_ch,
	axsd_out_if.source      out_ch
);

	logic                              valid_s1;
	logic [7:0]                        cipher_s1;
	logic                              last_s1;
	logic                              valid_s2;
	logic [7:0]                        plain_s2;
	logic                              last_s2;
	logic [axsd_pkg::KEY_IDX_W-1:0]    key_index_q;
	logic                              past_first_word_q;
	logic [axsd_pkg::HIST_W-1:0]       cipher_history_q;

	logic       s2_free;
	logic       move_s1;
	logic       accept;
	logic [7:0] kb;
	logic [7:0] chain_byte;
	logic [7:0] plain_d;

	assign s2_free     = !valid_s2 || out_ch.ready;
	assign move_s1     = valid_s1 && s2_free;
	assign in_ch.ready = !valid_s1 || s2_free;
	assign accept      = in_ch.valid && in_ch.ready;

	// In chained mode the first word of a member XORs its key byte twice,
	// so those bytes pass through unchanged.
	assign kb         = axsd_pkg::key_byte(cfg.key, key_index_q);
	assign chain_byte = past_first_word_q ? cipher_history_q[31:24] : kb;
	assign plain_d    = cipher_s1 ^ kb ^ (cfg.chained_mode ? chain_byte : 8'h00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cipher_s1 <= in_ch.cipher_byte;
			last_s1   <= in_ch.end_of_member;
		end
		if (move_s1) begin
			plain_s2 <= plain_d;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_index_q       <= '0;
			past_first_word_q <= 1'b0;
			cipher_history_q  <= '0;
		end else if (move_s1) begin
			if (last_s1) begin
				key_index_q       <= '0;
				past_first_word_q <= 1'b0;
				cipher_history_q  <= '0;
			end else begin
				if (key_index_q == axsd_pkg::FIRST_WORD_LAST_IDX) begin
					past_first_word_q <= 1'b1;
				end
				key_index_q      <= key_index_q + axsd_pkg::KEY_IDX_W'(1);
				cipher_history_q <= {cipher_history_q[axsd_pkg::HIST_W-9:0], cipher_s1};
			end
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.plain_byte = plain_s2;
	assign out_ch.last_out   = last_s2;

endmodule

@@ sim/archive_xor_stream_decryptor_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the archive stream decryptor: sends ciphertext requests with random gaps,
// predicts each plaintext byte and checks the results in order.
// Depends on axsd_pkg, the stream interfaces of axsd_if.sv and the decryptor itself.
module archive_xor_stream_decryptor_tb;

	localparam int RANDOM_BYTES = 1350;
	localparam int REG_SLOTS    = 2 ** axsd_pkg::CFG_IDX_W;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       last_out;
	} plain_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [axsd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [axsd_pkg::CFG_DATA_W-1:0] cfg_wdata;

	axsd_in_if  cipher_ch ();
	axsd_out_if plain_ch ();

	archive_xor_stream_decryptor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (cipher_ch),
		.out_ch    (plain_ch)
	);

	// Own copy of the decryptor's registers and member state.
	bit                         chained_q;
	logic [axsd_pkg::KEY_W-1:0] key_q;
	logic [3:0]                 pos_q;
	bit                         past_first_q;
	logic [31:0]                hist_q;

	plain_t plain_expected[$];
	int     mismatch_count;
	int     bytes_sent;
	int     member_left;
	bit     no_gaps;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic plain_t predict_plain(input logic [7:0] c, input logic last);
		plain_t     r;
		logic [7:0] kb;
		kb = key_q[pos_q*8 +: 8];
		r.plain_byte = c ^ kb;
		if (chained_q)
			r.plain_byte = r.plain_byte ^ (past_first_q ? hist_q[31:24] : kb);
		r.last_out = last;
		if (last) begin
			pos_q = '0;
			past_first_q = 1'b0;
			hist_q = '0;
		end else begin
			if (pos_q == axsd_pkg::FIRST_WORD_LAST_IDX)
				past_first_q = 1'b1;
			pos_q = pos_q + 4'd1;
			hist_q = {hist_q[23:0], c};
		end
		return r;
	endfunction

	function automatic int pick_gap();
		if (no_gaps || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic logic [31:0] pick_key_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic enqueue_expected(input plain_t r);
		plain_expected = {plain_expected, r};
	endtask

	task automatic set_reg(input int idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx[axsd_pkg::CFG_IDX_W-1:0];
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			axsd_pkg::REG_CHAINED_MODE: chained_q = data[0];
			axsd_pkg::REG_KEY_WORD_0:   key_q[31:0] = data;
			axsd_pkg::REG_KEY_WORD_1:   key_q[63:32] = data;
			axsd_pkg::REG_KEY_WORD_2:   key_q[95:64] = data;
			axsd_pkg::REG_KEY_WORD_3:   key_q[127:96] = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cipher_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cipher_ch.valid <= 1'b1;
		cipher_ch.cipher_byte <= c;
		cipher_ch.end_of_member <= last;
		do @(posedge clk); while (!cipher_ch.ready);
		enqueue_expected(predict_plain(c, last));
		bytes_sent++;
	endtask

	task automatic wait_drained();
		cipher_ch.valid <= 1'b0;
		while (plain_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Zero key after reset: every byte passes unchanged.
	task automatic test_reset_state();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_repeating_key();
		set_reg(axsd_pkg::REG_KEY_WORD_0, 32'hFFFF_FFFF);
		set_reg(axsd_pkg::REG_KEY_WORD_1, 32'h0000_0000);
		set_reg(axsd_pkg::REG_KEY_WORD_2, 32'hA55A_C33C);
		set_reg(axsd_pkg::REG_KEY_WORD_3, 32'h0123_4567);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h3C, 1'b1);
		wait_drained();
	endtask

	// Members whose length is not a multiple of four; only bit 0 of the mode write counts.
	task automatic test_chained_short_members();
		int lens[3] = '{1, 3, 5};
		set_reg(axsd_pkg::REG_CHAINED_MODE, 32'hFFFF_FFFF);
		foreach (lens[k])
			for (int j = 0; j < lens[k]; j++)
				send_byte(8'($urandom_range(0, 255)), j == lens[k] - 1);
		wait_drained();
	endtask

	// The member keeps its position and history while the mode flips under it.
	task automatic test_mode_switch_mid_member();
		send_byte(8'h81, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'hC3, 1'b0);
		wait_drained();
		set_reg(axsd_pkg::REG_CHAINED_MODE, 32'hFFFF_FFFE);
		send_byte(8'h18, 1'b0);
		send_byte(8'hE7, 1'b0);
		wait_drained();
		set_reg(axsd_pkg::REG_CHAINED_MODE, 32'h0000_0001);
		send_byte(8'h99, 1'b1);
		wait_drained();
	endtask

	task automatic test_ignored_index();
		for (int i = axsd_pkg::REG_KEY_WORD_3 + 1; i < REG_SLOTS; i++)
			set_reg(i, $urandom());
		send_byte(8'h42, 1'b0);
		send_byte(8'hBD, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int target;
		int phase_len;
		target = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < target) begin
			wait_drained();
			set_reg(axsd_pkg::REG_CHAINED_MODE, $urandom());
			for (int i = axsd_pkg::REG_KEY_WORD_0; i <= axsd_pkg::REG_KEY_WORD_3; i++)
				if ($urandom_range(0, 3) != 0)
					set_reg(i, pick_key_word());
			if ($urandom_range(0, 3) == 0)
				set_reg($urandom_range(axsd_pkg::REG_KEY_WORD_3 + 1, REG_SLOTS - 1),
					$urandom());
			no_gaps = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(40, 200);
			// A phase may stop inside a member, so the next setting applies mid-member.
			repeat (phase_len) begin
				if (member_left == 0)
					member_left = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 70) :
						$urandom_range(1, 24);
				member_left--;
				send_byte(8'($urandom_range(0, 255)), member_left == 0);
				if ($urandom_range(0, 99) == 0)
					wait_drained();
			end
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		plain_t want;
		if (arst_n && plain_ch.valid && plain_ch.ready) begin
			if (plain_expected.size() == 0) begin
				report_mismatch($sformatf("result %02h/%0b with nothing expected",
					plain_ch.plain_byte, plain_ch.last_out));
			end else begin
				want = plain_expected.pop_front();
				if (plain_ch.plain_byte !== want.plain_byte)
					report_mismatch($sformatf("plain_byte %02h, expected %02h",
						plain_ch.plain_byte, want.plain_byte));
				if (plain_ch.last_out !== want.last_out)
					report_mismatch($sformatf("last_out %0b, expected %0b",
						plain_ch.last_out, want.last_out));
			end
		end
	end

	// Result side: may hold ready low for a random gap before each result it takes.
	initial begin
		int stall;
		plain_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				plain_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			plain_ch.ready <= 1'b1;
			do @(posedge clk); while (!plain_ch.valid);
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		cipher_ch.valid <= 1'b0;
		cipher_ch.cipher_byte <= '0;
		cipher_ch.end_of_member <= 1'b0;
		chained_q = 1'b0;
		key_q = '0;
		pos_q = '0;
		past_first_q = 1'b0;
		hist_q = '0;
		mismatch_count = 0;
		bytes_sent = 0;
		member_left = 0;
		no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_repeating_key();
		test_chained_short_members();
		test_mode_switch_mid_member();
		test_ignored_index();
		test_random_traffic();

		wait_drained();
		if (mismatch_count == 0 && plain_expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
